/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold whenever the enable is high.
`define ASSERT_WHEN(label, en, cond, msg) \
    `ASSERT_CLK(label, (en) |-> (cond), msg)

`endif

/* rtl/tdq_pkg.sv */
package tdq_pkg;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned TIME_BITS   = 32;
    localparam int unsigned HANDLE_BITS = 8;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned OCC_W       = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W       = $clog2(DEPTH);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DUPLICATE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_REM_RD,
        S_REM_WR,
        S_INS_RD,
        S_INS_CHK,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_END,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_PACK_RD,
        S_PACK_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [HANDLE_BITS-1:0] handle;
        logic [TIME_BITS-1:0]   deadline;
        logic [TIME_BITS-1:0]   now;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   expired_valid;
        logic [HANDLE_BITS-1:0] expired_handle;
        logic [TIME_BITS-1:0]   expired_deadline;
        logic                   last;
    } rsp_t;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        logic [TIME_BITS-1:0]   deadline;
        logic [HANDLE_BITS-1:0] handle;
    } mem_wr_t;

    typedef struct packed {
        logic hnd_eq;
        logic le;
    } cmp_t;

endpackage

/* rtl/tdq_store.sv */
module tdq_store import tdq_pkg::*;
(
    input  logic                   clk,
    input  mem_wr_t                wr,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [TIME_BITS-1:0]   rd_deadline,
    output logic [HANDLE_BITS-1:0] rd_handle
);

    logic [TIME_BITS-1:0]   dl_mem [DEPTH];
    logic [HANDLE_BITS-1:0] hd_mem [DEPTH];
    logic [TIME_BITS-1:0]   rd_deadline_reg;
    logic [HANDLE_BITS-1:0] rd_handle_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            dl_mem[wr.addr] <= wr.deadline;
            hd_mem[wr.addr] <= wr.handle;
        end
        if (rd_en)
        begin
            rd_deadline_reg <= dl_mem[rd_addr];
            rd_handle_reg   <= hd_mem[rd_addr];
        end
    end

    assign rd_deadline = rd_deadline_reg;
    assign rd_handle   = rd_handle_reg;

endmodule

/* rtl/tdq_cmp.sv */
module tdq_cmp import tdq_pkg::*;
(
    input  logic [TIME_BITS-1:0]   a_deadline,
    input  logic [TIME_BITS-1:0]   b_deadline,
    input  logic [HANDLE_BITS-1:0] a_handle,
    input  logic [HANDLE_BITS-1:0] b_handle,
    output cmp_t                   res
);

    always_comb
    begin
        res.hnd_eq = (a_handle == b_handle);
        res.le     = (a_deadline <= b_deadline);
    end

endmodule

/* rtl/sorted_deadline_timer_queue.sv */
// Sorted timer list of DEPTH entries kept in a memory with one read and one write
// port, walked by a sequencer around one shared compare unit; each memory step is
// a read, then a compare or a write. Add, adjust and delete first search for the
// handle entry by entry, then remove and/or insert by shifting entries one at a
// time. Tick scans the expired entries from the front (at most MAX_RESULTS),
// emits them, waiting while the output is not taken, and compacts the rest; with
// none due it gives a single status response. The block takes a new item only
// when the previous one is done; the last result may still wait in the output
// register meanwhile.
`include "assert_macros.svh"

module sorted_deadline_timer_queue import tdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    state_t                 state_reg, state_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [OCC_W-1:0]       ptr_reg, ptr_next;
    logic [OCC_W-1:0]       cnt_reg, cnt_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [TIME_BITS-1:0]   dl_reg, dl_next;
    status_t                st_reg, st_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    mem_wr_t                wr;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [TIME_BITS-1:0]   rd_deadline;
    logic [HANDLE_BITS-1:0] rd_handle;
    cmp_t                   cmp;

    logic                   rsp_free;
    logic                   load_exp;
    logic [OCC_W-1:0]       ptr_inc;
    logic [OCC_W-1:0]       ptr_dec;
    logic [OCC_W:0]         ptr_plus_cnt;
    logic                   emit_last;

    tdq_store u_store
    (
        .clk         (clk),
        .wr          (wr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_deadline (rd_deadline),
        .rd_handle   (rd_handle)
    );

    tdq_cmp u_cmp
    (
        .a_deadline (rd_deadline),
        .b_deadline (dl_reg),
        .a_handle   (rd_handle),
        .b_handle   (hnd_reg),
        .res        (cmp)
    );

    assign rsp_free     = !rsp_valid_reg || rsp_ready;
    assign ptr_inc      = ptr_reg + OCC_W'(1);
    assign ptr_dec      = ptr_reg - OCC_W'(1);
    assign ptr_plus_cnt = {1'b0, ptr_reg} + {1'b0, cnt_reg};
    assign emit_last    = (ptr_inc == cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            cmd_reg       <= CMD_ADD;
            st_reg        <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            st_reg        <= st_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hnd_reg <= hnd_next;
        dl_reg  <= dl_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        hnd_next       = hnd_reg;
        dl_next        = dl_reg;
        st_next        = st_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        req_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr             = '0;
        load_exp       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next = cmd_t'(req.cmd);
                    hnd_next = req.handle;
                    dl_next  = (cmd_t'(req.cmd) == CMD_TICK) ? req.now : req.deadline;
                    st_next  = ST_OK;
                    ptr_next = '0;
                    state_next = (cmd_t'(req.cmd) == CMD_TICK) ? S_TICK_RD : S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                if (ptr_reg == occ_reg)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (occ_reg == OCC_W'(DEPTH))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg[IDX_W-1:0];
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK:
            begin
                if (cmp.hnd_eq)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        st_next    = ST_DUPLICATE;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_REM_RD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_FIND_RD;
                end
            end
            S_REM_RD:
            begin
                if ({1'b0, ptr_inc} >= {1'b0, occ_reg})
                begin
                    occ_next = occ_reg - OCC_W'(1);
                    if (cmd_reg == CMD_ADJUST)
                    begin
                        ptr_next   = occ_reg - OCC_W'(1);
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc[IDX_W-1:0];
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                wr.en       = 1'b1;
                wr.addr     = ptr_reg[IDX_W-1:0];
                wr.deadline = rd_deadline;
                wr.handle   = rd_handle;
                ptr_next    = ptr_inc;
                state_next  = S_REM_RD;
            end
            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    wr.en       = 1'b1;
                    wr.addr     = '0;
                    wr.deadline = dl_reg;
                    wr.handle   = hnd_reg;
                    occ_next    = occ_reg + OCC_W'(1);
                    state_next  = S_RESULT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_dec[IDX_W-1:0];
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                wr.en   = 1'b1;
                wr.addr = ptr_reg[IDX_W-1:0];
                if (!cmp.le)
                begin
                    wr.deadline = rd_deadline;
                    wr.handle   = rd_handle;
                    ptr_next    = ptr_dec;
                    state_next  = S_INS_RD;
                end
                else
                begin
                    wr.deadline = dl_reg;
                    wr.handle   = hnd_reg;
                    occ_next    = occ_reg + OCC_W'(1);
                    state_next  = S_RESULT;
                end
            end
            S_TICK_RD:
            begin
                if ((ptr_reg == occ_reg) || (32'(ptr_reg) == MAX_RESULTS))
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg[IDX_W-1:0];
                    state_next = S_TICK_CHK;
                end
            end
            S_TICK_CHK:
            begin
                if (cmp.le)
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_TICK_RD;
                end
                else
                begin
                    state_next = S_TICK_END;
                end
            end
            S_TICK_END:
            begin
                cnt_next   = ptr_reg;
                ptr_next   = '0;
                state_next = (ptr_reg == '0) ? S_RESULT : S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg[IDX_W-1:0];
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (rsp_free)
                begin
                    load_exp                  = 1'b1;
                    rsp_valid_next            = 1'b1;
                    rsp_next.status           = ST_OK;
                    rsp_next.expired_valid    = 1'b1;
                    rsp_next.expired_handle   = rd_handle;
                    rsp_next.expired_deadline = rd_deadline;
                    rsp_next.last             = emit_last;
                    if (emit_last)
                    begin
                        ptr_next   = '0;
                        state_next = S_PACK_RD;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_PACK_RD:
            begin
                if (ptr_plus_cnt >= {1'b0, occ_reg})
                begin
                    occ_next   = occ_reg - cnt_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_plus_cnt[IDX_W-1:0];
                    state_next = S_PACK_WR;
                end
            end
            S_PACK_WR:
            begin
                wr.en       = 1'b1;
                wr.addr     = ptr_reg[IDX_W-1:0];
                wr.deadline = rd_deadline;
                wr.handle   = rd_handle;
                ptr_next    = ptr_inc;
                state_next  = S_PACK_RD;
            end
            S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.status           = st_reg;
                    rsp_next.expired_valid    = 1'b0;
                    rsp_next.expired_handle   = '0;
                    rsp_next.expired_deadline = '0;
                    rsp_next.last             = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_CLK(a_occ_bound, occ_reg <= OCC_W'(DEPTH), "occupancy exceeds depth")
    `ASSERT_WHEN(a_exp_due, load_exp, rd_deadline <= dl_reg, "reported timer not yet due")
    `ASSERT_WHEN(a_emit_count, state_reg == S_EMIT_OUT, ptr_reg < cnt_reg, "emit past count")

endmodule
